[hdl/dsv_pkg.sv]
// Package for the date string validator: character codes, string length
// limits, the month length table and the string state bundle.
// Depends on nothing; dsv_verdict and date_string_validator use it.
package dsv_pkg;

  localparam logic [7:0] SlashCode = 8'h2F;
  localparam logic [7:0] DigitLo   = 8'h30;
  localparam logic [7:0] DigitHi   = 8'h39;

  localparam logic [3:0] StrLen  = 4'd10;
  localparam logic [3:0] PosSat  = 4'd11;
  localparam logic [3:0] SepPosA = 4'd2;
  localparam logic [3:0] SepPosB = 4'd5;
  localparam logic [3:0] YearPos = 4'd6;

  localparam logic [6:0] MonthMax = 7'd12;
  localparam logic [4:0] FebLeap  = 5'd29;

  localparam int unsigned YearDigits = 4;

  typedef logic [3:0] digit_t;

  // Everything the verdict needs about the string gathered so far.
  typedef struct packed {
    logic       format_good;
    logic [3:0] char_position;
    logic [6:0] day_acc;
    logic [6:0] month_acc;
    digit_t     yr_thousands;
    digit_t     yr_hundreds;
    digit_t     yr_tens;
    digit_t     yr_ones;
  } dsv_string_t;

  // Days in a common year; month is 1..12, other codes return 0.
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

[hdl/dsv_if.sv]
// Valid/ready channel interfaces for the date string validator.
// Depends on nothing; used by the top level.
interface dsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface dsv_out_if;
  logic        valid;
  logic        ready;
  logic        date_valid;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;

  modport source (output valid, output date_valid, output day, output month, output year,
                  input ready);
  modport sink   (input valid, input date_valid, input day, input month, input year,
                  output ready);
endinterface

[hdl/dsv_verdict.sv]
// Calendar check of a completed string: length, form, month range and
// day range with Gregorian leap years. Depends on dsv_pkg.
module dsv_verdict (
  input  dsv_pkg::dsv_string_t str_i,
  output logic                 ok_o
);

  logic [1:0] lo_mod4;
  logic [1:0] hi_mod4;
  logic       lo_zero;
  logic       leap;
  logic [4:0] lim;
  logic       month_ok;

  // A year abcd is divisible by 4 when (2c + d) is, by 100 when cd is 00,
  // and by 400 when additionally (2a + b) is divisible by 4.
  assign lo_mod4 = {str_i.yr_tens[0], 1'b0} + str_i.yr_ones[1:0];
  assign hi_mod4 = {str_i.yr_thousands[0], 1'b0} + str_i.yr_hundreds[1:0];
  assign lo_zero = (str_i.yr_tens == '0) && (str_i.yr_ones == '0);
  assign leap    = ((lo_mod4 == 2'd0) && !lo_zero) || (lo_zero && (hi_mod4 == 2'd0));

  assign month_ok = (str_i.month_acc != '0) && (str_i.month_acc <= dsv_pkg::MonthMax);

  always_comb begin
    lim = dsv_pkg::month_len(str_i.month_acc[3:0]);
    if ((str_i.month_acc == 7'd2) && leap) begin
      lim = dsv_pkg::FebLeap;
    end
    ok_o = str_i.format_good && (str_i.char_position == dsv_pkg::StrLen) && month_ok &&
           (str_i.day_acc != '0) && (str_i.day_acc <= {2'b00, lim});
  end

endmodule

[hdl/date_string_validator.sv]
// Date string validator, top level. Depends on dsv_pkg, dsv_if and dsv_verdict.
//
// The block reads a string one character per input transaction, followed by
// one transaction with end_of_string set, and checks that the string has the
// exact form dd/mm/yyyy and names a real Gregorian date. Character
// transactions produce no output. Each end transaction produces exactly one
// output transaction: date_valid tells whether the string passed, and day,
// month and year always carry the last date that passed (all zero after
// reset), so a failing string leaves them as they were. A new input
// transaction is taken in every cycle in which the input side does not stall;
// a verdict is presented in the cycle after its end transaction and held in
// the output register until the sink takes it. The input side stalls only
// while that output register is full and not being drained, so with a ready
// sink the throughput is one character per clock. Characters past the tenth
// are ignored except that they make the string too long.
module date_string_validator (
  input  logic          clk_i,
  input  logic          rst_ni,
  dsv_in_if.sink        in_i,
  dsv_out_if.source     out_o
);

  // String state that is built up while characters arrive.
  logic [3:0]             pos_q, pos_d;
  logic                   fmt_good_q, fmt_good_d;
  logic [6:0]             day_acc_q, day_acc_d;
  logic [6:0]             month_acc_q, month_acc_d;
  logic [13:0]            year_acc_q, year_acc_d;
  dsv_pkg::digit_t        yr_dig_q [dsv_pkg::YearDigits];
  dsv_pkg::digit_t        yr_dig_d [dsv_pkg::YearDigits];

  // Last accepted date and the output register.
  logic [4:0]             kept_day_q, kept_day_d;
  logic [3:0]             kept_month_q, kept_month_d;
  logic [13:0]            kept_year_q, kept_year_d;
  logic                   out_valid_q, out_valid_d;
  logic                   date_valid_q, date_valid_d;

  logic                   accept;
  logic                   is_digit;
  logic                   is_sep_pos;
  logic [3:0]             digit;
  logic [1:0]             yr_idx;
  logic                   ok;
  dsv_pkg::dsv_string_t   str;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign is_digit   = (in_i.char_code >= dsv_pkg::DigitLo) &&
                      (in_i.char_code <= dsv_pkg::DigitHi);
  assign digit      = in_i.char_code[3:0];
  assign is_sep_pos = (pos_q == dsv_pkg::SepPosA) || (pos_q == dsv_pkg::SepPosB);
  // Positions 6..9 map onto year digit slots 0..3.
  assign yr_idx     = pos_q[1:0] - dsv_pkg::YearPos[1:0];

  assign str.format_good   = fmt_good_q;
  assign str.char_position = pos_q;
  assign str.day_acc       = day_acc_q;
  assign str.month_acc     = month_acc_q;
  assign str.yr_thousands  = yr_dig_q[0];
  assign str.yr_hundreds   = yr_dig_q[1];
  assign str.yr_tens       = yr_dig_q[2];
  assign str.yr_ones       = yr_dig_q[3];

  dsv_verdict u_verdict (
    .str_i (str),
    .ok_o  (ok)
  );

  always_comb begin
    pos_d        = pos_q;
    fmt_good_d   = fmt_good_q;
    day_acc_d    = day_acc_q;
    month_acc_d  = month_acc_q;
    year_acc_d   = year_acc_q;
    yr_dig_d     = yr_dig_q;
    kept_day_d   = kept_day_q;
    kept_month_d = kept_month_q;
    kept_year_d  = kept_year_q;
    date_valid_d = date_valid_q;
    out_valid_d  = out_valid_q && !out_o.ready;

    if (accept && !in_i.end_of_string) begin
      // A character: check it against its position and fold digits into
      // the field they belong to.
      if (pos_q < dsv_pkg::StrLen) begin
        if (is_sep_pos) begin
          if (in_i.char_code != dsv_pkg::SlashCode) begin
            fmt_good_d = 1'b0;
          end
        end else if (is_digit) begin
          if (pos_q < dsv_pkg::SepPosA) begin
            day_acc_d = (day_acc_q << 3) + (day_acc_q << 1) + {3'b000, digit};
          end else if (pos_q < dsv_pkg::SepPosB) begin
            month_acc_d = (month_acc_q << 3) + (month_acc_q << 1) + {3'b000, digit};
          end else begin
            year_acc_d = (year_acc_q << 3) + (year_acc_q << 1) + {10'd0, digit};
            yr_dig_d[yr_idx] = digit;
          end
        end else begin
          fmt_good_d = 1'b0;
        end
      end
      if (pos_q < dsv_pkg::PosSat) begin
        pos_d = pos_q + 4'd1;
      end
    end else if (accept) begin
      // The terminator: deliver the verdict and start a fresh string.
      out_valid_d  = 1'b1;
      date_valid_d = ok;
      if (ok) begin
        kept_day_d   = day_acc_q[4:0];
        kept_month_d = month_acc_q[3:0];
        kept_year_d  = year_acc_q;
      end
      pos_d       = '0;
      fmt_good_d  = 1'b1;
      day_acc_d   = '0;
      month_acc_d = '0;
      year_acc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      fmt_good_q   <= 1'b1;
      day_acc_q    <= '0;
      month_acc_q  <= '0;
      year_acc_q   <= '0;
      kept_day_q   <= '0;
      kept_month_q <= '0;
      kept_year_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      fmt_good_q   <= fmt_good_d;
      day_acc_q    <= day_acc_d;
      month_acc_q  <= month_acc_d;
      year_acc_q   <= year_acc_d;
      kept_day_q   <= kept_day_d;
      kept_month_q <= kept_month_d;
      kept_year_q  <= kept_year_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Year digits and the verdict flag are payload; they are only looked at
  // once the string or the output register says they are meaningful.
  always_ff @(posedge clk_i) begin
    yr_dig_q     <= yr_dig_d;
    date_valid_q <= date_valid_d;
  end

  // The kept date can only change on an end transaction, which is accepted
  // only once the previous verdict has been taken, so it doubles as payload.
  assign out_o.valid      = out_valid_q;
  assign out_o.date_valid = date_valid_q;
  assign out_o.day        = kept_day_q;
  assign out_o.month      = kept_month_q;
  assign out_o.year       = kept_year_q;

endmodule

[hdl/dsv_checker.sv]
// Port-level checks for the date string validator, bound to the top level.
// Depends on date_string_validator and dsv_if.
module dsv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_end_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        date_valid_i,
  input logic [4:0]  day_i,
  input logic [3:0]  month_i,
  input logic [13:0] year_i
);

  // A verdict appears only right after a terminator transaction.
  a_verdict_follows_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !$past(out_valid_i && !out_ready_i)) |->
      $past(in_valid_i && in_ready_i && in_end_i))
    else $error("output transaction without a preceding end transaction");

  // A passing verdict carries a nonzero day, a month of 1..12 and a year of at most 9999.
  a_valid_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && date_valid_i) |->
      (day_i != 5'd0 && month_i != 4'd0 && month_i <= 4'd12 && year_i <= 14'd9999))
    else $error("accepted date out of range");

  // A failing verdict repeats the date of the previous verdict.
  a_fail_keeps_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i) ##1 (out_valid_i && !date_valid_i) |->
      ($stable(day_i) && $stable(month_i) && $stable(year_i)))
    else $error("failing verdict changed the kept date");

  // A stalled verdict holds its payload.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(date_valid_i) && $stable(day_i) && $stable(month_i) &&
       $stable(year_i)))
    else $error("stalled output transaction changed");

endmodule

bind date_string_validator dsv_checker u_dsv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_end_i     (in_i.end_of_string),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .date_valid_i (out_o.date_valid),
  .day_i        (out_o.day),
  .month_i      (out_o.month),
  .year_i       (out_o.year)
);
